[hw/rtl/mstk_pkg.sv]
// Shared constants and types for the Kruskal spanning tree core.
`timescale 1ns / 1ps
package mstk_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int WeightBits  = 16;
  localparam int VidBits     = 6;
  localparam int CfgBits     = 7;
  localparam int CfgReset    = 64;

  // Input item kinds carried on tuser
  localparam logic FuncLoad    = 1'b0;
  localparam logic FuncCompute = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN_RD  = 7'b0000010,
    ST_SCAN_CMP = 7'b0000100,
    ST_FIND_RD  = 7'b0001000,
    ST_FIND_CHK = 7'b0010000,
    ST_UNION    = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

endpackage

[hw/rtl/mstk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/minimum_spanning_tree_kruskal_core.sv]
// Top level of the Kruskal minimum spanning tree core.
//
// Input stream: tuser is the item kind (0 load edge, 1 compute). A load writes
// {end_b, end_a, weight} into the edge store; loads beyond MAX_EDGES or with
// an endpoint not below the vertex count are dropped and set a sticky drop
// flag. A compute item holds tready low while the core runs: each selection
// pass scans the stored edges through one shared key comparator, picking the
// smallest key above the last one taken; the picked edge then walks the parent
// forest RAM to both roots. Kept edges leave in weight order, tlast on the final
// one; a compute that keeps nothing gives one item flagged empty in tuser.
// Output items sit in an output register; a stalled receiver holds the
// sequencer only when it has a new item to hand over.
// Reset: store empty, forest all roots, drop flag clear, vertex count 64.
// After each compute the store, forest and drop flag are cleared again.
`timescale 1ns / 1ps
module minimum_spanning_tree_kruskal_core #(
  parameter int MAX_VERTICES = mstk_pkg::MaxVertices,
  parameter int MAX_EDGES    = mstk_pkg::MaxEdges,
  parameter int WEIGHT_BITS  = mstk_pkg::WeightBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration: vertex_count
  input  logic                        cfg_we_i,
  input  logic [mstk_pkg::CfgBits-1:0] cfg_wdata_i,
  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: edge_weight, end_a, end_b (lowest bit up)
  input  logic [((WEIGHT_BITS+2*mstk_pkg::VidBits+7)/8)*8-1:0] s_axis_tdata,
  // tuser: func
  input  logic [0:0] s_axis_tuser,
  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: tree_weight, tree_end_a, tree_end_b (lowest bit up)
  output logic [((WEIGHT_BITS+2*mstk_pkg::VidBits+7)/8)*8-1:0] m_axis_tdata,
  // tuser: is_empty, dropped_seen (lowest bit up)
  output logic [1:0] m_axis_tuser,
  output logic       m_axis_tlast
);

  localparam int VB = mstk_pkg::VidBits;
  localparam int EW = WEIGHT_BITS + 2 * VB;
  localparam int DW = ((EW + 7) / 8) * 8;
  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int KB = mstk_pkg::CfgBits;

  mstk_pkg::state_e state_q, state_d;

  logic [KB-1:0]          vcount_q;
  logic [CW-1:0]          total_q;
  logic                   drop_q;
  logic [MAX_VERTICES-1:0] fvalid_q;
  logic [CW-1:0]          idx_q;
  logic [EW-1:0]          prev_q, best_q;
  logic                   have_prev_q, best_valid_q;
  logic [VW-1:0]          v_q, root_a_q;
  logic                   side_q;
  logic                   pend_valid_q;
  logic                   out_valid_q;
  // payload
  logic [WEIGHT_BITS-1:0] cur_w_q, pend_w_q, out_w_q;
  logic [VB-1:0]          cur_a_q, cur_b_q, pend_a_q, pend_b_q, out_a_q, out_b_q;
  logic                   out_empty_q, out_drop_q, out_last_q;

  // Unpack input item
  logic [WEIGHT_BITS-1:0] in_w;
  logic [VB-1:0]          in_a, in_b;
  logic                   in_fire, load_fire, comp_fire, load_ok;
  logic [KB-1:0]          nv;

  assign in_w = s_axis_tdata[WEIGHT_BITS-1:0];
  assign in_a = s_axis_tdata[WEIGHT_BITS+:VB];
  assign in_b = s_axis_tdata[WEIGHT_BITS+VB+:VB];

  assign s_axis_tready = (state_q == mstk_pkg::ST_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign load_fire = in_fire && (s_axis_tuser[0] == mstk_pkg::FuncLoad);
  assign comp_fire = in_fire && (s_axis_tuser[0] == mstk_pkg::FuncCompute);

  // Clamp the vertex count to the forest size
  assign nv = (vcount_q > KB'(MAX_VERTICES)) ? KB'(MAX_VERTICES) : vcount_q;
  assign load_ok = (total_q != CW'(MAX_EDGES))
                && (KB'(in_a) < nv) && (KB'(in_b) < nv);

  // Edge store
  logic [EW-1:0] e_rd;
  mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (load_fire && load_ok),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i ({in_b, in_a, in_w}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (e_rd)
  );

  // Parent forest; an entry without its valid bit is its own parent
  logic          f_we;
  logic [VW-1:0] f_rd;
  mstk_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_forest_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (root_a_q),
    .wdata_i (v_q),
    .raddr_i (v_q),
    .rdata_o (f_rd)
  );

  // Shared key comparator: weight (sign flipped), then end_a, then end_b
  logic [EW-1:0] cur_key, best_n;
  logic          take, best_v_n, last_idx;
  assign cur_key = {~e_rd[WEIGHT_BITS-1], e_rd[WEIGHT_BITS-2:0],
                    e_rd[WEIGHT_BITS+:VB], e_rd[WEIGHT_BITS+VB+:VB]};
  assign take = (!have_prev_q || (cur_key > prev_q))
             && (!best_valid_q || (cur_key < best_q));
  assign best_v_n = best_valid_q || take;
  assign best_n   = take ? cur_key : best_q;
  assign last_idx = ((idx_q + CW'(1)) == total_q);

  logic [VW-1:0] parent;
  assign parent = fvalid_q[v_q] ? f_rd : v_q;

  logic slot_free, is_kept, out_set;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign is_kept   = (root_a_q != v_q);
  assign f_we      = (state_q == mstk_pkg::ST_UNION) && is_kept
                  && (!pend_valid_q || slot_free);
  assign out_set   = ((state_q == mstk_pkg::ST_UNION) && f_we && pend_valid_q)
                  || ((state_q == mstk_pkg::ST_DONE) && slot_free);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mstk_pkg::ST_IDLE: begin
        if (comp_fire) begin
          state_d = (total_q == '0) ? mstk_pkg::ST_DONE : mstk_pkg::ST_SCAN_RD;
        end
      end
      mstk_pkg::ST_SCAN_RD:  state_d = mstk_pkg::ST_SCAN_CMP;
      mstk_pkg::ST_SCAN_CMP: begin
        if (last_idx) begin
          state_d = best_v_n ? mstk_pkg::ST_FIND_RD : mstk_pkg::ST_DONE;
        end else begin
          state_d = mstk_pkg::ST_SCAN_RD;
        end
      end
      mstk_pkg::ST_FIND_RD:  state_d = mstk_pkg::ST_FIND_CHK;
      mstk_pkg::ST_FIND_CHK: begin
        if ((parent == v_q) && side_q) begin
          state_d = mstk_pkg::ST_UNION;
        end else begin
          state_d = mstk_pkg::ST_FIND_RD;
        end
      end
      mstk_pkg::ST_UNION: begin
        if (!is_kept || !pend_valid_q || slot_free) begin
          state_d = mstk_pkg::ST_SCAN_RD;
        end
      end
      mstk_pkg::ST_DONE: begin
        if (slot_free) begin
          state_d = mstk_pkg::ST_IDLE;
        end
      end
      default: state_d = mstk_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mstk_pkg::ST_IDLE;
      vcount_q     <= KB'(mstk_pkg::CfgReset);
      total_q      <= '0;
      drop_q       <= 1'b0;
      fvalid_q     <= '0;
      idx_q        <= '0;
      have_prev_q  <= 1'b0;
      best_valid_q <= 1'b0;
      side_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      // load a new output item, or drop the one taken
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        mstk_pkg::ST_IDLE: begin
          if (load_fire) begin
            if (load_ok) total_q <= total_q + CW'(1);
            else         drop_q  <= 1'b1;
          end
          idx_q        <= '0;
          have_prev_q  <= 1'b0;
          best_valid_q <= 1'b0;
        end
        mstk_pkg::ST_SCAN_RD: ;
        mstk_pkg::ST_SCAN_CMP: begin
          if (last_idx) begin
            idx_q        <= '0;
            best_valid_q <= 1'b0;
            if (best_v_n) begin
              have_prev_q <= 1'b1;
              side_q      <= 1'b0;
            end
          end else begin
            idx_q        <= idx_q + CW'(1);
            best_valid_q <= best_v_n;
          end
        end
        mstk_pkg::ST_FIND_RD: ;
        mstk_pkg::ST_FIND_CHK: begin
          if (parent == v_q) begin
            side_q <= 1'b1;
          end
        end
        mstk_pkg::ST_UNION: begin
          if (f_we) begin
            fvalid_q[root_a_q] <= 1'b1;
            pend_valid_q       <= 1'b1;
          end
        end
        mstk_pkg::ST_DONE: begin
          if (slot_free) begin
            pend_valid_q <= 1'b0;
            total_q      <= '0;
            fvalid_q     <= '0;
            drop_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mstk_pkg::ST_SCAN_CMP: begin
        if (last_idx && best_v_n) begin
          prev_q  <= best_n;
          cur_w_q <= {~best_n[EW-1], best_n[EW-2:2*VB]};
          cur_a_q <= best_n[2*VB-1:VB];
          cur_b_q <= best_n[VB-1:0];
          v_q     <= best_n[VB+:VW];
        end else begin
          best_q <= best_n;
        end
      end
      mstk_pkg::ST_FIND_CHK: begin
        if (parent != v_q) begin
          v_q <= parent;
        end else if (!side_q) begin
          root_a_q <= v_q;
          v_q      <= cur_b_q[VW-1:0];
        end
      end
      mstk_pkg::ST_UNION: begin
        if (f_we) begin
          if (pend_valid_q) begin
            out_w_q     <= pend_w_q;
            out_a_q     <= pend_a_q;
            out_b_q     <= pend_b_q;
            out_empty_q <= 1'b0;
            out_drop_q  <= drop_q;
            out_last_q  <= 1'b0;
          end
          pend_w_q <= cur_w_q;
          pend_a_q <= cur_a_q;
          pend_b_q <= cur_b_q;
        end
      end
      mstk_pkg::ST_DONE: begin
        if (slot_free) begin
          out_w_q     <= pend_valid_q ? pend_w_q : '0;
          out_a_q     <= pend_valid_q ? pend_a_q : '0;
          out_b_q     <= pend_valid_q ? pend_b_q : '0;
          out_empty_q <= !pend_valid_q;
          out_drop_q  <= drop_q;
          out_last_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DW'({out_b_q, out_a_q, out_w_q});
  assign m_axis_tuser  = {out_drop_q, out_empty_q};
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_EDGES))
    else $error("edge count above store size");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("empty result with edge data or without last");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_fire |=> !s_axis_tready)
    else $error("compute item did not start the sequencer");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mstk_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("pending tree edge left after compute");

endmodule
